// ===== rtl/assert_macros.svh =====
// assertion helpers used by the rtl table unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/hftc_pkg.sv =====
`timescale 1ns / 1ps
package hftc_pkg;

  localparam int unsigned NumSymbols = 256;

  localparam logic [8:0] LastEntry  = 9'(NumSymbols);
  localparam logic [8:0] ScanEnd    = 9'(NumSymbols + 1);
  localparam logic [8:0] LinkNull   = 9'h1FF;
  localparam logic [8:0] HistDepth  = 9'd32;
  localparam logic [7:0] LastSym    = 8'(NumSymbols - 1);
  localparam logic [5:0] SizeSat    = 6'd63;
  localparam logic [5:0] MaxRawSize = 6'd32;
  localparam logic [4:0] MaxCodeLen = 5'd16;
  localparam logic [4:0] HistTop    = 5'd31;
  localparam logic [4:0] DropTop    = 5'd15;

  typedef enum logic [1:0] {
    OpLoad     = 2'd0,
    OpBuild    = 2'd1,
    OpReadCode = 2'd2,
    OpReadLen  = 2'd3
  } op_e;

  typedef enum logic [30:0] {
    S_RST   = 31'h0000_0001,
    S_IDLE  = 31'h0000_0002,
    S_INIT  = 31'h0000_0004,
    S_SCAN  = 31'h0000_0008,
    S_MRG1  = 31'h0000_0010,
    S_MRG2  = 31'h0000_0020,
    S_WRD   = 31'h0000_0040,
    S_WWR   = 31'h0000_0080,
    S_HRD   = 31'h0000_0100,
    S_HCHK  = 31'h0000_0200,
    S_HINC  = 31'h0000_0400,
    S_FRDI  = 31'h0000_0800,
    S_FCHKI = 31'h0000_1000,
    S_FSRCH = 31'h0000_2000,
    S_FU1A  = 31'h0000_4000,
    S_FU1B  = 31'h0000_8000,
    S_FU2A  = 31'h0001_0000,
    S_FU2B  = 31'h0002_0000,
    S_FU3   = 31'h0004_0000,
    S_DRD   = 31'h0008_0000,
    S_DCHK  = 31'h0010_0000,
    S_ARD   = 31'h0020_0000,
    S_ACHK  = 31'h0040_0000,
    S_AGIVE = 31'h0080_0000,
    S_AHIST = 31'h0100_0000,
    S_CRD   = 31'h0200_0000,
    S_CCHK  = 31'h0400_0000,
    S_CHB   = 31'h0800_0000,
    S_CNB   = 31'h1000_0000,
    S_ERR   = 31'h2000_0000,
    S_DONE  = 31'h4000_0000
  } state_e;

  typedef struct packed {
    logic [5:0] size;
    logic [8:0] link;
  } node_t;

  typedef struct packed {
    logic [4:0]  len;
    logic [15:0] code;
  } code_t;

endpackage

// ===== rtl/huffman_table_from_counts_unit.sv =====
`timescale 1ns / 1ps
// channel  | handshake             | fields
// ---------+-----------------------+------------------------------------------------
// command  | start, busy (in/out)  | operation_i, symbol_i, count_i
// result   | done_o (1-cycle pulse)| status_o, code_length_o, code_value_o,
//          |                       | length_count_o
//
// loads and reads may follow back to back; a read answers
// with done_o in the cycle after it is taken, a load gives no word back
// a build holds busy through the init, merge scan, histogram, fold and drop, length
// hand-out and canonical code passes, run as single-port scans of the count, node
// and code memories; an oversized build clears the code and histogram memories
// instead
// after reset busy stays high while the count, histogram and code memories are
// swept to their reset contents
// the receiver cannot stall: each done_o pulse is a word that is taken
`include "assert_macros.svh"

module huffman_table_from_counts_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  symbol_i,
  input  logic [23:0] count_i,
  output logic        done_o,
  output logic        status_o,
  output logic [4:0]  code_length_o,
  output logic [15:0] code_value_o,
  output logic [8:0]  length_count_o
);

  // sequencer state
  hftc_pkg::state_e state_q, state_d;
  logic [8:0]  idx_q, idx_d;
  logic        err_q, err_d;

  // two-smallest scan over the count memory
  logic        pend_q, pend_d;
  logic [8:0]  pidx_q, pidx_d;
  logic        has1_q, has1_d, has2_q, has2_d;
  logic [8:0]  v1_q, v1_d, v2_q, v2_d;
  logic [31:0] f1_q, f1_d, f2_q, f2_d;

  // chain walk
  logic [8:0]  cur_q, cur_d;
  logic        phase_q, phase_d;

  // histogram, fold and drop
  logic [4:0]  hidx_q, hidx_d;
  logic [4:0]  fi_q, fi_d, fj_q, fj_d;
  logic [8:0]  hi_q, hi_d, hj_q, hj_d;

  // length hand-out and canonical codes
  logic [5:0]  sz_q, sz_d;
  logic [4:0]  len_cur_q, len_cur_d;
  logic [8:0]  rem_q, rem_d;
  logic [4:0]  cl_q, cl_d;
  logic [16:0] base_q, base_d, code_q, code_d;

  // result word
  logic             resp_q, resp_d;
  hftc_pkg::op_e    rkind_q, rkind_d;
  logic             roor_q, roor_d;

  // memory ports
  logic        fr_we;
  logic [8:0]  fr_wa, fr_ra;
  logic [31:0] fr_wd, fr_rd;
  logic        nd_we;
  logic [8:0]  nd_wa, nd_ra;
  hftc_pkg::node_t nd_wd, nd_rd;
  logic        hs_we;
  logic [4:0]  hs_wa, hs_ra;
  logic [8:0]  hs_wd, hs_rd;
  logic        ct_we;
  logic [7:0]  ct_wa, ct_ra;
  hftc_pkg::code_t ct_wd, ct_rd;

  // counts per entry, last entry is the reserved symbol
  logic [31:0] freq_mem [257];
  // raw size and merge link per entry
  hftc_pkg::node_t node_mem [257];
  // codes per length, index is length minus one
  logic [8:0]  hist_mem [32];
  // length and code per symbol
  hftc_pkg::code_t code_mem [256];

  always_ff @(posedge clk_i) begin
    if (fr_we) begin
      freq_mem[fr_wa] <= fr_wd;
    end
    fr_rd <= freq_mem[fr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nd_we) begin
      node_mem[nd_wa] <= nd_wd;
    end
    nd_rd <= node_mem[nd_ra];
  end

  always_ff @(posedge clk_i) begin
    if (hs_we) begin
      hist_mem[hs_wa] <= hs_wd;
    end
    hs_rd <= hist_mem[hs_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ct_we) begin
      code_mem[ct_wa] <= ct_wd;
    end
    ct_rd <= code_mem[ct_ra];
  end

  logic        acc;
  logic        scan_nz, scan_b1, scan_b2;
  logic [5:0]  size_inc, szm1;
  logic [31:0] fsum;
  logic [16:0] bsum;

  assign busy = (state_q != hftc_pkg::S_IDLE);
  assign acc  = start && !busy;

  assign scan_nz  = (fr_rd != 32'd0);
  assign scan_b1  = !has1_q || (fr_rd <= f1_q);
  assign scan_b2  = !has2_q || (fr_rd <= f2_q);
  assign size_inc = (nd_rd.size == hftc_pkg::SizeSat) ? nd_rd.size : nd_rd.size + 6'd1;
  assign szm1     = nd_rd.size - 6'd1;
  assign fsum     = f1_q + f2_q;
  assign bsum     = base_q + 17'(hs_rd);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    err_d     = err_q;
    pend_d    = pend_q;
    pidx_d    = pidx_q;
    has1_d    = has1_q;
    has2_d    = has2_q;
    v1_d      = v1_q;
    v2_d      = v2_q;
    f1_d      = f1_q;
    f2_d      = f2_q;
    cur_d     = cur_q;
    phase_d   = phase_q;
    hidx_d    = hidx_q;
    fi_d      = fi_q;
    fj_d      = fj_q;
    hi_d      = hi_q;
    hj_d      = hj_q;
    sz_d      = sz_q;
    len_cur_d = len_cur_q;
    rem_d     = rem_q;
    cl_d      = cl_q;
    base_d    = base_q;
    code_d    = code_q;
    resp_d    = 1'b0;
    rkind_d   = rkind_q;
    roor_d    = roor_q;

    fr_we = 1'b0;
    fr_wa = idx_q;
    fr_wd = 32'd0;
    fr_ra = idx_q;
    nd_we = 1'b0;
    nd_wa = idx_q;
    nd_wd = '{size: 6'd0, link: hftc_pkg::LinkNull};
    nd_ra = idx_q;
    hs_we = 1'b0;
    hs_wa = idx_q[4:0];
    hs_wd = 9'd0;
    hs_ra = {1'b0, symbol_i[3:0]};
    ct_we = 1'b0;
    ct_wa = idx_q[7:0];
    ct_wd = '{len: 5'd0, code: 16'd0};
    ct_ra = symbol_i;

    unique case (state_q)
      // sweep counts, histogram and codes to their reset contents
      hftc_pkg::S_RST: begin
        fr_we = 1'b1;
        fr_wd = (idx_q == hftc_pkg::LastEntry) ? 32'd1 : 32'd0;
        ct_we = (idx_q != hftc_pkg::LastEntry);
        hs_we = (idx_q < hftc_pkg::HistDepth);
        if (idx_q == hftc_pkg::LastEntry) begin
          state_d = hftc_pkg::S_IDLE;
        end else begin
          idx_d = idx_q + 9'd1;
        end
      end

      hftc_pkg::S_IDLE: begin
        if (acc) begin
          unique case (hftc_pkg::op_e'(operation_i))
            hftc_pkg::OpLoad: begin
              fr_we = 1'b1;
              fr_wa = {1'b0, symbol_i};
              fr_wd = {8'd0, count_i};
            end
            hftc_pkg::OpBuild: begin
              err_d   = 1'b0;
              idx_d   = 9'd0;
              state_d = hftc_pkg::S_INIT;
            end
            hftc_pkg::OpReadCode: begin
              resp_d  = 1'b1;
              rkind_d = hftc_pkg::OpReadCode;
            end
            hftc_pkg::OpReadLen: begin
              resp_d  = 1'b1;
              rkind_d = hftc_pkg::OpReadLen;
              roor_d  = (symbol_i[7:4] != 4'd0);
            end
            default: ;
          endcase
        end
      end

      // sizes to zero, links to null, histogram cleared
      hftc_pkg::S_INIT: begin
        nd_we = 1'b1;
        hs_we = (idx_q < hftc_pkg::HistDepth);
        if (idx_q == hftc_pkg::LastEntry) begin
          state_d = hftc_pkg::S_SCAN;
          idx_d   = 9'd0;
          pend_d  = 1'b0;
          has1_d  = 1'b0;
          has2_d  = 1'b0;
        end else begin
          idx_d = idx_q + 9'd1;
        end
      end

      // one read per cycle, compare the word of the previous cycle
      hftc_pkg::S_SCAN: begin
        if (idx_q != hftc_pkg::ScanEnd) begin
          idx_d  = idx_q + 9'd1;
          pend_d = 1'b1;
          pidx_d = idx_q;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && scan_nz) begin
          if (scan_b1) begin
            has2_d = has1_q;
            v2_d   = v1_q;
            f2_d   = f1_q;
            has1_d = 1'b1;
            v1_d   = pidx_q;
            f1_d   = fr_rd;
          end else if (scan_b2) begin
            has2_d = 1'b1;
            v2_d   = pidx_q;
            f2_d   = fr_rd;
          end
        end
        if (pend_q && (pidx_q == hftc_pkg::LastEntry)) begin
          pend_d = 1'b0;
          idx_d  = 9'd0;
          if (has2_d) begin
            state_d = hftc_pkg::S_MRG1;
          end else begin
            state_d = hftc_pkg::S_HRD;
          end
        end
      end

      hftc_pkg::S_MRG1: begin
        fr_we   = 1'b1;
        fr_wa   = v1_q;
        fr_wd   = fsum;
        state_d = hftc_pkg::S_MRG2;
      end

      hftc_pkg::S_MRG2: begin
        fr_we   = 1'b1;
        fr_wa   = v2_q;
        cur_d   = v1_q;
        phase_d = 1'b0;
        state_d = hftc_pkg::S_WRD;
      end

      hftc_pkg::S_WRD: begin
        nd_ra   = cur_q;
        state_d = hftc_pkg::S_WWR;
      end

      // bump one node; at the tail of the first chain hook on the second
      hftc_pkg::S_WWR: begin
        nd_we = 1'b1;
        nd_wa = cur_q;
        nd_wd = '{size: size_inc, link: nd_rd.link};
        if (nd_rd.link == hftc_pkg::LinkNull) begin
          if (!phase_q) begin
            nd_wd   = '{size: size_inc, link: v2_q};
            cur_d   = v2_q;
            phase_d = 1'b1;
            state_d = hftc_pkg::S_WRD;
          end else begin
            state_d = hftc_pkg::S_SCAN;
            idx_d   = 9'd0;
            pend_d  = 1'b0;
            has1_d  = 1'b0;
            has2_d  = 1'b0;
          end
        end else begin
          cur_d   = nd_rd.link;
          state_d = hftc_pkg::S_WRD;
        end
      end

      // size histogram, counts cleared on the same pass
      hftc_pkg::S_HRD: begin
        nd_ra   = idx_q;
        fr_we   = 1'b1;
        fr_wd   = (idx_q == hftc_pkg::LastEntry) ? 32'd1 : 32'd0;
        state_d = hftc_pkg::S_HCHK;
      end

      hftc_pkg::S_HCHK, hftc_pkg::S_HINC: begin
        if (state_q == hftc_pkg::S_HINC) begin
          hs_we = 1'b1;
          hs_wa = hidx_q;
          hs_wd = hs_rd + 9'd1;
        end
        if ((state_q == hftc_pkg::S_HCHK) && (nd_rd.size > hftc_pkg::MaxRawSize)) begin
          err_d = 1'b1;
        end
        if ((state_q == hftc_pkg::S_HCHK) && (nd_rd.size <= hftc_pkg::MaxRawSize) &&
            (nd_rd.size != 6'd0)) begin
          hs_ra   = szm1[4:0];
          hidx_d  = szm1[4:0];
          state_d = hftc_pkg::S_HINC;
        end else if (idx_q == hftc_pkg::LastEntry) begin
          idx_d = 9'd0;
          if (err_d) begin
            state_d = hftc_pkg::S_ERR;
          end else begin
            fi_d    = hftc_pkg::HistTop;
            state_d = hftc_pkg::S_FRDI;
          end
        end else begin
          idx_d   = idx_q + 9'd1;
          state_d = hftc_pkg::S_HRD;
        end
      end

      // fold lengths above the limit
      hftc_pkg::S_FRDI: begin
        hs_ra   = fi_q;
        state_d = hftc_pkg::S_FCHKI;
      end

      hftc_pkg::S_FCHKI: begin
        if (hs_rd == 9'd0) begin
          if (fi_q == hftc_pkg::MaxCodeLen) begin
            fi_d    = hftc_pkg::DropTop;
            state_d = hftc_pkg::S_DRD;
          end else begin
            fi_d    = fi_q - 5'd1;
            state_d = hftc_pkg::S_FRDI;
          end
        end else begin
          hi_d    = hs_rd;
          fj_d    = fi_q - 5'd2;
          hs_ra   = fi_q - 5'd2;
          state_d = hftc_pkg::S_FSRCH;
        end
      end

      hftc_pkg::S_FSRCH: begin
        if ((hs_rd == 9'd0) && (fj_q != 5'd0)) begin
          fj_d  = fj_q - 5'd1;
          hs_ra = fj_q - 5'd1;
        end else begin
          hj_d  = hs_rd;
          hs_we = 1'b1;
          hs_wa = fi_q;
          if ((hs_rd == 9'd0) || (hi_q < 9'd2)) begin
            state_d = hftc_pkg::S_FRDI;
          end else begin
            hs_wd   = hi_q - 9'd2;
            state_d = hftc_pkg::S_FU1A;
          end
        end
      end

      hftc_pkg::S_FU1A: begin
        hs_ra   = fi_q - 5'd1;
        state_d = hftc_pkg::S_FU1B;
      end

      hftc_pkg::S_FU1B: begin
        hs_we   = 1'b1;
        hs_wa   = fi_q - 5'd1;
        hs_wd   = hs_rd + 9'd1;
        state_d = hftc_pkg::S_FU2A;
      end

      hftc_pkg::S_FU2A: begin
        hs_ra   = fj_q + 5'd1;
        state_d = hftc_pkg::S_FU2B;
      end

      hftc_pkg::S_FU2B: begin
        hs_we   = 1'b1;
        hs_wa   = fj_q + 5'd1;
        hs_wd   = hs_rd + 9'd2;
        state_d = hftc_pkg::S_FU3;
      end

      hftc_pkg::S_FU3: begin
        hs_we   = 1'b1;
        hs_wa   = fj_q;
        hs_wd   = hj_q - 9'd1;
        state_d = hftc_pkg::S_FRDI;
      end

      // take the reserved code off the longest used length
      hftc_pkg::S_DRD: begin
        hs_ra   = fi_q;
        state_d = hftc_pkg::S_DCHK;
      end

      hftc_pkg::S_DCHK: begin
        if ((hs_rd == 9'd0) && (fi_q != 5'd0)) begin
          fi_d    = fi_q - 5'd1;
          state_d = hftc_pkg::S_DRD;
        end else begin
          hs_we     = (hs_rd != 9'd0);
          hs_wa     = fi_q;
          hs_wd     = hs_rd - 9'd1;
          idx_d     = 9'd0;
          sz_d      = 6'd1;
          len_cur_d = 5'd0;
          rem_d     = 9'd0;
          state_d   = hftc_pkg::S_ARD;
        end
      end

      // hand out lengths by raw size then symbol; first pass clears the rest
      hftc_pkg::S_ARD: begin
        nd_ra   = {1'b0, idx_q[7:0]};
        state_d = hftc_pkg::S_ACHK;
      end

      hftc_pkg::S_ACHK, hftc_pkg::S_AGIVE, hftc_pkg::S_AHIST: begin
        if (state_q == hftc_pkg::S_AHIST) begin
          rem_d     = hs_rd;
          len_cur_d = len_cur_q + 5'd1;
          state_d   = hftc_pkg::S_AGIVE;
        end else if ((state_q == hftc_pkg::S_ACHK) && (nd_rd.size == sz_q)) begin
          state_d = hftc_pkg::S_AGIVE;
        end else if ((state_q == hftc_pkg::S_AGIVE) && (rem_q == 9'd0) &&
                     (len_cur_q != hftc_pkg::MaxCodeLen)) begin
          hs_ra   = len_cur_q;
          state_d = hftc_pkg::S_AHIST;
        end else begin
          if (state_q == hftc_pkg::S_AGIVE) begin
            ct_we = 1'b1;
            if (rem_q != 9'd0) begin
              ct_wd = '{len: len_cur_q, code: 16'd0};
              rem_d = rem_q - 9'd1;
            end
          end else begin
            ct_we = (sz_q == 6'd1);
          end
          state_d = hftc_pkg::S_ARD;
          if (idx_q[7:0] == hftc_pkg::LastSym) begin
            idx_d = 9'd0;
            if (sz_q == hftc_pkg::MaxRawSize) begin
              cl_d    = 5'd1;
              base_d  = 17'd0;
              code_d  = 17'd0;
              state_d = hftc_pkg::S_CRD;
            end else begin
              sz_d = sz_q + 6'd1;
            end
          end else begin
            idx_d = idx_q + 9'd1;
          end
        end
      end

      // canonical codes, ascending by symbol within a length
      hftc_pkg::S_CRD: begin
        ct_ra   = idx_q[7:0];
        state_d = hftc_pkg::S_CCHK;
      end

      hftc_pkg::S_CCHK: begin
        if (ct_rd.len == cl_q) begin
          ct_we  = 1'b1;
          ct_wd  = '{len: cl_q, code: code_q[15:0]};
          code_d = code_q + 17'd1;
        end
        if (idx_q[7:0] == hftc_pkg::LastSym) begin
          idx_d   = 9'd0;
          state_d = hftc_pkg::S_CHB;
        end else begin
          idx_d   = idx_q + 9'd1;
          state_d = hftc_pkg::S_CRD;
        end
      end

      hftc_pkg::S_CHB: begin
        hs_ra   = cl_q - 5'd1;
        state_d = hftc_pkg::S_CNB;
      end

      // next length starts at (first code + count) shifted left
      hftc_pkg::S_CNB: begin
        base_d = {bsum[15:0], 1'b0};
        code_d = {bsum[15:0], 1'b0};
        if (cl_q == hftc_pkg::MaxCodeLen) begin
          state_d = hftc_pkg::S_DONE;
        end else begin
          cl_d    = cl_q + 5'd1;
          state_d = hftc_pkg::S_CRD;
        end
      end

      // oversized code: empty code and histogram memories
      hftc_pkg::S_ERR: begin
        ct_we = 1'b1;
        hs_we = (idx_q < hftc_pkg::HistDepth);
        if (idx_q[7:0] == hftc_pkg::LastSym) begin
          state_d = hftc_pkg::S_DONE;
        end else begin
          idx_d = idx_q + 9'd1;
        end
      end

      hftc_pkg::S_DONE: begin
        resp_d  = 1'b1;
        rkind_d = hftc_pkg::OpBuild;
        state_d = hftc_pkg::S_IDLE;
      end

      default: begin
        state_d = hftc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hftc_pkg::S_RST;
      idx_q   <= 9'd0;
      err_q   <= 1'b0;
      pend_q  <= 1'b0;
      has1_q  <= 1'b0;
      has2_q  <= 1'b0;
      phase_q <= 1'b0;
      resp_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      err_q   <= err_d;
      pend_q  <= pend_d;
      has1_q  <= has1_d;
      has2_q  <= has2_d;
      phase_q <= phase_d;
      resp_q  <= resp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q    <= pidx_d;
    v1_q      <= v1_d;
    v2_q      <= v2_d;
    f1_q      <= f1_d;
    f2_q      <= f2_d;
    cur_q     <= cur_d;
    hidx_q    <= hidx_d;
    fi_q      <= fi_d;
    fj_q      <= fj_d;
    hi_q      <= hi_d;
    hj_q      <= hj_d;
    sz_q      <= sz_d;
    len_cur_q <= len_cur_d;
    rem_q     <= rem_d;
    cl_q      <= cl_d;
    base_q    <= base_d;
    code_q    <= code_d;
    rkind_q   <= rkind_d;
    roor_q    <= roor_d;
  end

  // result word, fields valid while done_o is high
  assign done_o         = resp_q;
  assign status_o       = err_q;
  assign code_length_o  = (rkind_q == hftc_pkg::OpReadCode) ? ct_rd.len : 5'd0;
  assign code_value_o   = (rkind_q == hftc_pkg::OpReadCode) ? ct_rd.code : 16'd0;
  assign length_count_o = ((rkind_q == hftc_pkg::OpReadLen) && !roor_q) ? hs_rd : 9'd0;

  `ASSERT_AT(a_done_idle, done_o |-> (state_q == hftc_pkg::S_IDLE), "word out while busy")
  `ASSERT_AT(a_build_busy, (acc && (operation_i == 2'(hftc_pkg::OpBuild))) |=> busy, "build not taken")
  `ASSERT_NEVER(a_walk_null, (state_q == hftc_pkg::S_WRD) && (cur_q > hftc_pkg::LastEntry), "walk on null link")
  `ASSERT_AT(a_fold_order, (state_q == hftc_pkg::S_FSRCH) |-> ((fj_q + 5'd2) <= fi_q), "fold search past target")
  `ASSERT_AT(a_len_range, (state_q == hftc_pkg::S_AGIVE) |-> (len_cur_q <= hftc_pkg::MaxCodeLen), "length beyond limit")

endmodule

// ===== bench/tb_huffman_table_from_counts_unit.sv =====
`timescale 1ns / 1ps
module tb_huffman_table_from_counts_unit;

  // one expected answer word
  typedef struct {
    logic        status;
    logic [4:0]  len;
    logic [15:0] code;
    logic [8:0]  lcount;
  } answer_t;

  // table builder model plus queue of answers still owed by the block
  class huff_scoreboard;
    int unsigned freq[257];
    int          raw_size[257];
    int          link[257];
    logic [8:0]  hist[16];
    logic [20:0] codes[256];
    logic        build_err;
    answer_t     owed[$];
    int          errors;

    function new();
      foreach (freq[e]) freq[e] = 0;
      freq[256] = 1;
      foreach (hist[l]) hist[l] = '0;
      foreach (codes[s]) codes[s] = '0;
      build_err = 1'b0;
      errors = 0;
    endfunction

    // grow every raw size along a merge chain
    function void grow_chain(int e);
      int steps;
      steps = 0;
      forever begin
        if (raw_size[e] < 63) raw_size[e]++;
        if (link[e] == 511 || steps >= 257) break;
        e = link[e];
        steps++;
      end
    endfunction

    function int chain_end(int e);
      int steps;
      steps = 0;
      while (link[e] != 511 && steps < 257) begin
        e = link[e];
        steps++;
      end
      return e;
    endfunction

    function void build_table();
      int h[32];
      int order[256];
      int lens[256];
      int sym_seq[256];
      int v1, v2, i, j, k, n, pos;
      bit has1, has2;
      int unsigned code;
      foreach (raw_size[e]) begin
        raw_size[e] = 0;
        link[e] = 511;
      end
      // merge the two rarest entries until one remains, ties to higher index
      forever begin
        has1 = 0; has2 = 0; v1 = 0; v2 = 0;
        for (int e = 0; e <= 256; e++)
          if (freq[e] != 0 && (!has1 || freq[e] <= freq[v1])) begin
            v1 = e; has1 = 1;
          end
        for (int e = 0; e <= 256; e++)
          if (e != v1 && freq[e] != 0 && (!has2 || freq[e] <= freq[v2])) begin
            v2 = e; has2 = 1;
          end
        if (!has1 || !has2) break;
        freq[v1] += freq[v2];
        freq[v2] = 0;
        grow_chain(v1);
        link[chain_end(v1)] = v2;
        grow_chain(v2);
      end
      // counts are consumed by the build
      foreach (freq[e]) freq[e] = 0;
      freq[256] = 1;
      foreach (h[l]) h[l] = 0;
      build_err = 1'b0;
      for (int e = 0; e <= 256; e++)
        if (raw_size[e] > 32) build_err = 1'b1;
        else if (raw_size[e] != 0) h[raw_size[e] - 1]++;
      foreach (hist[l]) hist[l] = '0;
      foreach (codes[s]) codes[s] = '0;
      if (build_err) return;
      // fold lengths above 16 bits down
      i = 31;
      while (1) begin
        if (h[i] > 0) begin
          j = i - 1;
          do j--; while (h[j] == 0 && j > 0);
          if (h[j] == 0 || h[i] < 2) begin
            h[i] = 0;
            continue;
          end
          h[i] -= 2;
          h[i - 1] += 1;
          h[j + 1] += 2;
          h[j] -= 1;
        end else begin
          i--;
          if (i == 15) break;
        end
      end
      // remove the reserved all-ones code from the longest length
      k = 15;
      while (k > 0 && h[k] == 0) k--;
      if (h[k] > 0) h[k]--;
      for (int l = 0; l < 16; l++) hist[l] = 9'(h[l]);
      // hand lengths out by raw size, then symbol
      n = 0;
      for (int s = 1; s <= 32; s++)
        for (int e = 0; e < 256; e++)
          if (raw_size[e] == s) order[n++] = e;
      foreach (lens[e]) lens[e] = 0;
      pos = 0;
      for (int l = 0; l < 16; l++)
        for (int c = 0; c < h[l]; c++) begin
          if (pos < n) lens[order[pos]] = l + 1;
          pos++;
        end
      k = 0;
      for (int l = 1; l <= 16; l++)
        for (int e = 0; e < 256; e++)
          if (lens[e] == l) sym_seq[k++] = e;
      n = k;
      // canonical codes, ascending by symbol within a length
      code = 0;
      k = 0;
      for (int l = 1; l <= 16; l++) begin
        for (int c = 0; c < h[l - 1]; c++) begin
          if (k < n) codes[sym_seq[k]] = {5'(l), code[15:0]};
          code++;
          k++;
        end
        code = (code << 1) & 32'h1FFFF;
      end
    endfunction

    // note one accepted command word
    function void note_command(hftc_pkg::op_e op, logic [7:0] sym, logic [23:0] cnt);
      answer_t a;
      a = '{status: 1'b0, len: '0, code: '0, lcount: '0};
      case (op)
        hftc_pkg::OpLoad: begin
          freq[sym] = cnt;
          return;
        end
        hftc_pkg::OpBuild: build_table();
        hftc_pkg::OpReadCode: begin
          a.len = codes[sym][20:16];
          a.code = codes[sym][15:0];
        end
        hftc_pkg::OpReadLen: if (sym < 16) a.lcount = hist[sym];
      endcase
      a.status = build_err;
      owed = {owed, a};
    endfunction

    function void check_answer(logic st, logic [4:0] ln, logic [15:0] cd, logic [8:0] lc);
      answer_t a;
      if (owed.size() == 0) begin
        $display("%0t unexpected answer word: status %0d len %0d code %h count %0d",
                 $time, st, ln, cd, lc);
        errors++;
        return;
      end
      a = owed.pop_front();
      if (st !== a.status) begin
        $display("%0t status expected %0d actual %0d", $time, a.status, st);
        errors++;
      end
      if (ln !== a.len) begin
        $display("%0t code_length expected %0d actual %0d", $time, a.len, ln);
        errors++;
      end
      if (cd !== a.code) begin
        $display("%0t code_value expected %h actual %h", $time, a.code, cd);
        errors++;
      end
      if (lc !== a.lcount) begin
        $display("%0t length_count expected %0d actual %0d", $time, a.lcount, lc);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation_i = '0;
  logic [7:0]  symbol_i = '0;
  logic [23:0] count_i = '0;
  logic        done_o;
  logic        status_o;
  logic [4:0]  code_length_o;
  logic [15:0] code_value_o;
  logic [8:0]  length_count_o;

  huff_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  no_gaps = 0;

  always #1 clk_i = ~clk_i;

  huffman_table_from_counts_unit uut (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .symbol_i, .count_i,
    .done_o, .status_o, .code_length_o, .code_value_o, .length_count_o
  );

  // every done pulse is a word that must be taken
  always @(posedge clk_i)
    if (rst_ni && done_o) sb.check_answer(status_o, code_length_o, code_value_o, length_count_o);

  // watchdog on cycles with no word moving either way
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 1000000) begin
      $display("huffman_table_from_counts_unit: mismatch");
      $finish;
    end
  end

  // present one command word and hold it until taken; start stays high unless a gap follows
  task automatic send_word(hftc_pkg::op_e op, logic [7:0] sym, logic [23:0] cnt);
    int r, gap;
    bit taken;
    start <= 1'b1;
    operation_i <= op;
    symbol_i <= sym;
    count_i <= cnt;
    // busy is sampled mid-cycle, before the edge that may take the word
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    sb.note_command(op, sym, cnt);
    // mostly back to back, some short gaps, a few long ones
    r = $urandom_range(0, 99);
    gap = no_gaps ? 0 : (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off until all answers are in, then build
  task automatic build_now();
    start <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    send_word(hftc_pkg::OpBuild, 8'($urandom), 24'($urandom));
  endtask

  task automatic read_back(int nreads, int lo, int hi);
    for (int r = 0; r < nreads; r++)
      if ($urandom_range(0, 2) != 0)
        send_word(hftc_pkg::OpReadCode, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                  : 8'($urandom_range(lo, hi)), 24'($urandom));
      else
        send_word(hftc_pkg::OpReadLen, ($urandom_range(0, 4) == 0) ? 8'($urandom)
                  : 8'($urandom_range(0, 17)), 24'($urandom));
  endtask

  // fibonacci counts give the deepest trees for a given symbol count
  task automatic load_fib(int nsyms, int base);
    int unsigned a, b, t;
    a = 1; b = 1;
    for (int s = 0; s < nsyms; s++) begin
      send_word(hftc_pkg::OpLoad, 8'(base + s), 24'(a));
      t = a + b; a = b; b = t;
    end
  endtask

  initial begin
    int nsyms, base;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reads from reset, empty build, extremes of the fields
    send_word(hftc_pkg::OpReadCode, 8'd0, 24'd0);
    send_word(hftc_pkg::OpReadLen, 8'd255, 24'hFFFFFF);
    build_now();
    read_back(4, 0, 3);
    send_word(hftc_pkg::OpLoad, 8'd255, 24'hFFFFFF);
    send_word(hftc_pkg::OpLoad, 8'd0, 24'd1);
    send_word(hftc_pkg::OpLoad, 8'd128, 24'd1);
    send_word(hftc_pkg::OpLoad, 8'd128, 24'd0);
    build_now();
    send_word(hftc_pkg::OpReadCode, 8'd255, 24'd0);
    send_word(hftc_pkg::OpReadCode, 8'd0, 24'd0);
    send_word(hftc_pkg::OpReadCode, 8'd128, 24'd0);
    send_word(hftc_pkg::OpReadLen, 8'd0, 24'd0);
    send_word(hftc_pkg::OpReadLen, 8'd15, 24'd0);
    send_word(hftc_pkg::OpReadLen, 8'd16, 24'd0);
    // deep tree that needs folding, then one too deep to build
    load_fib(22, 10);
    build_now();
    read_back(6, 10, 31);
    load_fib(36, 200);
    build_now();
    read_back(4, 200, 235);
    // counts were consumed, so this build is empty again
    build_now();
    send_word(hftc_pkg::OpReadLen, 8'd0, 24'd0);

    // random sets, mostly small, one full alphabet
    for (int set = 0; set < 18; set++) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      nsyms = (set == 9) ? 256 : $urandom_range(1, 24);
      base = (nsyms == 256) ? 0 : $urandom_range(0, 256 - nsyms);
      if (set % 6 == 5) load_fib($urandom_range(17, 30), base % 200);
      else
        for (int s = 0; s < nsyms; s++)
          send_word(hftc_pkg::OpLoad, 8'(base + s),
                    ($urandom_range(0, 3) == 0) ? 24'($urandom) :
                    ($urandom_range(0, 5) == 0) ? 24'd0 : 24'($urandom_range(1, 40)));
      build_now();
      read_back(30, base, (nsyms == 256) ? 255 : base + nsyms - 1);
    end
    start <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0)
      $display("huffman_table_from_counts_unit: match");
    else
      $display("huffman_table_from_counts_unit: mismatch");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hftc_pkg.sv
rtl/huffman_table_from_counts_unit.sv
bench/tb_huffman_table_from_counts_unit.sv
